FILE: rtl/tks_pkg.sv
// Shared types and constants for the topological sort engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package tks_pkg;

  localparam int VTX_W            = 7;
  localparam int MAX_VERTICES_DEF = 64;

  localparam logic [VTX_W-1:0] VC_RESET = 7'd64;

  // Request codes.
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [VTX_W-1:0] edge_from;
    logic [VTX_W-1:0] edge_to;
  } tks_req_t;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic             is_last;
    logic             cycle_found;
  } tks_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic edge_load;
    logic edge_wr;
    logic run_init;
    logic s_inc;
    logic row_load;
    logic bit_adv;
    logic deg_dec;
    logic enq_mode;
    logic init_clr;
    logic init_chk;
    logic deq_get;
    logic finish;
  } tks_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic edge_ok;
    logic disc_done;
    logic row_bit;
    logic scan_done;
    logic init_done;
    logic q_empty;
  } tks_stat_t;

endpackage

FILE: rtl/tks_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the adjacency rows, in-degree counters and ready queue.
module tks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/tks_ctrl.sv
// Controller state machine of the topological sort engine.
// Depends on tks_pkg for the command and status structs.
module tks_ctrl import tks_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      req_type,
  input  tks_stat_t stat,
  output tks_cmd_t  cmd,
  output logic      busy
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_E_RD    = 4'd1;
  localparam logic [3:0] S_E_WR    = 4'd2;
  localparam logic [3:0] S_D_CHK   = 4'd3;
  localparam logic [3:0] S_ROW_RD  = 4'd4;
  localparam logic [3:0] S_ROW_LD  = 4'd5;
  localparam logic [3:0] S_SCAN    = 4'd6;
  localparam logic [3:0] S_SCAN_WR = 4'd7;
  localparam logic [3:0] S_I_RD    = 4'd8;
  localparam logic [3:0] S_I_CHK   = 4'd9;
  localparam logic [3:0] S_P_DEQ   = 4'd10;
  localparam logic [3:0] S_P_GET   = 4'd11;
  localparam logic [3:0] S_FIN     = 4'd12;

  logic [3:0] state, state_next;
  // Low while rows above the vertex count are discounted, high while sorting.
  logic       mode, mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

  always_comb begin
    state_next   = state;
    mode_next    = mode;
    cmd          = '0;
    cmd.enq_mode = mode;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_EDGE: begin
              if (stat.edge_ok) begin
                cmd.edge_load = 1'b1;
                state_next    = S_E_RD;
              end
            end
            REQ_RUN: begin
              cmd.run_init = 1'b1;
              mode_next    = 1'b0;
              state_next   = S_D_CHK;
            end
            default: ;
          endcase
        end
      end
      S_E_RD: begin
        state_next = S_E_WR;
      end
      S_E_WR: begin
        cmd.edge_wr = 1'b1;
        state_next  = S_IDLE;
      end
      S_D_CHK: begin
        if (stat.disc_done) begin
          cmd.init_clr = 1'b1;
          mode_next    = 1'b1;
          state_next   = S_I_RD;
        end else begin
          state_next = S_ROW_LD;
        end
      end
      S_ROW_RD: begin
        state_next = S_ROW_LD;
      end
      S_ROW_LD: begin
        cmd.row_load = 1'b1;
        state_next   = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          if (mode) begin
            state_next = S_P_DEQ;
          end else begin
            cmd.s_inc  = 1'b1;
            state_next = S_D_CHK;
          end
        end else if (stat.row_bit) begin
          state_next = S_SCAN_WR;
        end else begin
          cmd.bit_adv = 1'b1;
        end
      end
      S_SCAN_WR: begin
        cmd.deg_dec = 1'b1;
        cmd.bit_adv = 1'b1;
        state_next  = S_SCAN;
      end
      S_I_RD: begin
        if (stat.init_done) begin
          state_next = S_P_DEQ;
        end else begin
          state_next = S_I_CHK;
        end
      end
      S_I_CHK: begin
        cmd.init_chk = 1'b1;
        state_next   = S_I_RD;
      end
      S_P_DEQ: begin
        if (stat.q_empty) begin
          state_next = S_FIN;
        end else begin
          state_next = S_P_GET;
        end
      end
      S_P_GET: begin
        cmd.deq_get = 1'b1;
        state_next  = S_ROW_RD;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: rtl/tks_dp.sv
// Datapath of the topological sort engine: graph memories, ready queue,
// counters and result register. Depends on tks_pkg and tks_ram.
module tks_dp import tks_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tks_req_t          req,
  input  tks_cmd_t          cmd,
  output tks_stat_t         stat,
  input  logic              cfg_we,
  input  logic [VTX_W-1:0]  cfg_data,
  output logic              result_valid,
  output tks_result_t       result
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);
  localparam logic [VTX_W-1:0] MAX_VTX = VTX_W'(MAX_VERTICES);

  logic [VTX_W-1:0]        vc;
  logic [CNT_W-1:0]        n_eff;
  logic [VTX_W-1:0]        n_vtx;

  logic [CNT_W-1:0]        s_idx, t_idx;
  logic [IDX_W-1:0]        s_ix, t_ix;
  logic [MAX_VERTICES-1:0] row;
  logic [CNT_W-1:0]        head, tail, emitted;
  logic [VTX_W-1:0]        pend;
  logic                    pend_v;

  logic [MAX_VERTICES-1:0] adj_valid, deg_valid;
  logic                    adj_rv, deg_rv;

  logic [MAX_VERTICES-1:0] adj_rdata, row_masked, adj_wdata;
  logic                    adj_we, new_edge;
  logic [CNT_W-1:0]        deg_rdata, deg_masked, deg_wdata;
  logic                    deg_we;
  logic [IDX_W-1:0]        q_rdata;
  logic                    q_we, enq_req;

  // A vertex count of zero acts as one, a count above the maximum as the maximum.
  always_comb begin
    if (vc == '0) begin
      n_eff = CNT_W'(1);
    end else if (vc > MAX_VTX) begin
      n_eff = MAX_CNT;
    end else begin
      n_eff = CNT_W'(vc);
    end
  end
  assign n_vtx = VTX_W'(n_eff);

  assign s_ix = s_idx[IDX_W-1:0];
  assign t_ix = t_idx[IDX_W-1:0];

  // Entries whose valid bit is clear read as zero, which is the cleared graph.
  assign row_masked = adj_rv ? adj_rdata : '0;
  assign deg_masked = deg_rv ? deg_rdata : '0;

  assign new_edge  = !row_masked[t_ix];
  assign adj_we    = cmd.edge_wr && new_edge;
  assign adj_wdata = row_masked | ({{(MAX_VERTICES-1){1'b0}}, 1'b1} << t_ix);

  assign deg_we    = (cmd.edge_wr && new_edge) || (cmd.deg_dec && (deg_masked != '0));
  assign deg_wdata = cmd.edge_wr ? (deg_masked + CNT_W'(1)) : (deg_masked - CNT_W'(1));

  assign enq_req = (cmd.init_chk && (deg_masked == '0)) ||
                   (cmd.deg_dec && cmd.enq_mode && (deg_masked == CNT_W'(1)));
  assign q_we    = enq_req && (tail < MAX_CNT);

  tks_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (s_ix),
    .wdata (adj_wdata),
    .raddr (s_ix),
    .rdata (adj_rdata)
  );

  tks_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (t_ix),
    .wdata (deg_wdata),
    .raddr (t_ix),
    .rdata (deg_rdata)
  );

  tks_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VERTICES)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (tail[IDX_W-1:0]),
    .wdata (t_ix),
    .raddr (head[IDX_W-1:0]),
    .rdata (q_rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vc           <= VC_RESET;
      adj_valid    <= '0;
      deg_valid    <= '0;
      adj_rv       <= 1'b0;
      deg_rv       <= 1'b0;
      head         <= '0;
      tail         <= '0;
      emitted      <= '0;
      pend_v       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.finish || (cmd.deq_get && pend_v);
      adj_rv       <= adj_valid[s_ix];
      deg_rv       <= deg_valid[t_ix];
      if (cfg_we) begin
        vc <= cfg_data;
      end
      if (cmd.finish) begin
        adj_valid    <= '0;
        deg_valid    <= '0;
      end else begin
        if (adj_we) begin
          adj_valid[s_ix] <= 1'b1;
        end
        if (deg_we) begin
          deg_valid[t_ix] <= 1'b1;
        end
      end
      if (q_we) begin
        tail <= tail + CNT_W'(1);
      end
      if (cmd.init_clr) begin
        head    <= '0;
        tail    <= '0;
        emitted <= '0;
        pend_v  <= 1'b0;
      end
      if (cmd.deq_get) begin
        head    <= head + CNT_W'(1);
        emitted <= emitted + CNT_W'(1);
        pend_v  <= 1'b1;
      end
    end
  end

  // Payload registers. A dequeued vertex is held back one step so that the
  // last one of the run can carry the final flags.
  always_ff @(posedge clk) begin
    if (cmd.edge_load) begin
      s_idx <= CNT_W'(req.edge_from - VTX_W'(1));
      t_idx <= CNT_W'(req.edge_to - VTX_W'(1));
    end
    if (cmd.run_init) begin
      s_idx <= n_eff;
    end
    if (cmd.s_inc) begin
      s_idx <= s_idx + CNT_W'(1);
    end
    if (cmd.row_load) begin
      row   <= row_masked;
      t_idx <= '0;
    end
    if (cmd.bit_adv) begin
      row   <= row >> 1;
      t_idx <= t_idx + CNT_W'(1);
    end
    if (cmd.init_clr) begin
      t_idx <= '0;
    end
    if (cmd.init_chk) begin
      t_idx <= t_idx + CNT_W'(1);
    end
    if (cmd.deq_get) begin
      s_idx <= CNT_W'(q_rdata);
      pend  <= VTX_W'(q_rdata) + VTX_W'(1);
      if (pend_v) begin
        result.vertex      <= pend;
        result.is_last     <= 1'b0;
        result.cycle_found <= 1'b0;
      end
    end
    if (cmd.finish) begin
      if (pend_v) begin
        result.vertex      <= pend;
        result.is_last     <= 1'b1;
        result.cycle_found <= (emitted < n_eff);
      end else begin
        result.vertex      <= '0;
        result.is_last     <= 1'b1;
        result.cycle_found <= 1'b1;
      end
    end
  end

  assign stat.edge_ok   = (req.edge_from != '0) && (req.edge_from <= n_vtx) &&
                          (req.edge_to != '0) && (req.edge_to <= n_vtx);
  assign stat.disc_done = (s_idx == MAX_CNT);
  assign stat.row_bit   = row[0];
  assign stat.scan_done = (t_idx == n_eff) || (row == '0);
  assign stat.init_done = (t_idx == n_eff);
  assign stat.q_empty   = (head == tail);

  a_queue_order: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("ready queue read pointer passed the write pointer");

  a_deq_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.deq_get |-> (head != tail))
    else $error("dequeue commanded on an empty ready queue");

  a_cycle_on_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.cycle_found) |-> result.is_last)
    else $error("cycle flag raised on a result that is not the last");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.is_last) |=> !result_valid)
    else $error("result strobed after the last result of a run");

endmodule

FILE: rtl/topological_sort_kahn_top.sv
// Top level of the topological sort engine: controller plus datapath.
// Depends on tks_pkg, tks_ctrl, tks_dp (and tks_ram through tks_dp).
//
// A transaction is taken when start is high and busy is low. An edge request
// gives no result and is ignored if an endpoint is out of range. A run first
// walks the adjacency rows above the vertex count, scanning each row up to its
// highest edge, then reads the in-degree counter of every vertex up to the
// count, then for each dequeued vertex scans its row up to its highest
// out-edge and decrements the in-degree of each out-edge target. The row scan
// is bit serial. Results appear one per cycle of result_valid with no
// back-pressure, each vertex one dequeue after it was taken, the last one in
// the same cycle that busy falls. The graph is clear after reset and after
// every run with no clearing pass.
module topological_sort_kahn_top import tks_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  tks_req_t         req,
  output logic             result_valid,
  output tks_result_t      result,
  input  logic             cfg_we,
  input  logic [VTX_W-1:0] cfg_data
);

  tks_cmd_t  cmd;
  tks_stat_t stat;

  tks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  tks_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
